### hw/rtl/srpi_pkg.sv
// ----------------------------------------------------------------------------
// srpi_pkg: shared types and constants for the sensor rate/position integrator
// Register indexes, reset values, field widths and state encodings.
// ----------------------------------------------------------------------------
package srpi_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  // normalization and position ranges
  localparam int NORM_LOW      = 0;
  localparam int NORM_HIGH     = 100;
  localparam int POSITION_LOW  = 0;
  localparam int POSITION_HIGH = 100;

  // field widths
  localparam int HELD_W    = 8;
  localparam int POS_OUT_W = 7;
  localparam int SPEED_W   = 9;
  localparam int ANGLE_W   = 8;
  localparam int STOP_W    = 7;
  localparam int COEF_W    = 8;   // magnitude bits of the small multiplier operand
  localparam int SPEED_SAT = 255;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_LOW,
    REG_STOP_HIGH,
    REG_FWD_MIN,
    REG_FWD_MAX,
    REG_REV_MIN,
    REG_REV_MAX,
    REG_OPEN_ANGLE,
    REG_CLOSE_ANGLE
  } reg_idx_t;

  localparam logic [STOP_W-1:0]         RST_STOP_LOW    = 7'd40;
  localparam logic [STOP_W-1:0]         RST_STOP_HIGH   = 7'd60;
  localparam logic signed [COEF_W-1:0]  RST_FWD_MIN     = 8'sh00;
  localparam logic signed [COEF_W-1:0]  RST_FWD_MAX     = 8'sh08;
  localparam logic signed [COEF_W-1:0]  RST_REV_MIN     = 8'shF8;
  localparam logic signed [COEF_W-1:0]  RST_REV_MAX     = 8'sh00;
  localparam logic [ANGLE_W-1:0]        RST_OPEN_ANGLE  = 8'd0;
  localparam logic [ANGLE_W-1:0]        RST_CLOSE_ANGLE = 8'd180;

  typedef struct packed {
    logic [STOP_W-1:0]        stop_low;
    logic [STOP_W-1:0]        stop_high;
    logic signed [COEF_W-1:0] fwd_min;
    logic signed [COEF_W-1:0] fwd_max;
    logic signed [COEF_W-1:0] rev_min;
    logic signed [COEF_W-1:0] rev_max;
    logic [ANGLE_W-1:0]       open_angle;
    logic [ANGLE_W-1:0]       close_angle;
  } cfg_t;

  // item mode codes
  typedef enum logic [1:0] {
    MODE_RUN,
    MODE_RESTART,
    MODE_UPDATE
  } mode_t;

  // item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_NORM_WAIT,
    ST_SPEED,
    ST_SPEED_WAIT,
    ST_POS,
    ST_ANGLE_WAIT,
    ST_OUT
  } seq_state_t;

  // serial multiply/divide unit
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

### hw/rtl/srpi_cfg.sv
// ----------------------------------------------------------------------------
// srpi_cfg: configuration register file
// Eight write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module srpi_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [srpi_pkg::CFG_IDX_W-1:0]    index,
  input  logic [srpi_pkg::CFG_DATA_W-1:0]   data,
  output srpi_pkg::cfg_t                    regs
);
  import srpi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stop_low    <= RST_STOP_LOW;
      regs.stop_high   <= RST_STOP_HIGH;
      regs.fwd_min     <= RST_FWD_MIN;
      regs.fwd_max     <= RST_FWD_MAX;
      regs.rev_min     <= RST_REV_MIN;
      regs.rev_max     <= RST_REV_MAX;
      regs.open_angle  <= RST_OPEN_ANGLE;
      regs.close_angle <= RST_CLOSE_ANGLE;
    end else if (we) begin
      case (reg_idx_t'(index))
        REG_STOP_LOW:    regs.stop_low    <= data[STOP_W-1:0];
        REG_STOP_HIGH:   regs.stop_high   <= data[STOP_W-1:0];
        REG_FWD_MIN:     regs.fwd_min     <= $signed(data[COEF_W-1:0]);
        REG_FWD_MAX:     regs.fwd_max     <= $signed(data[COEF_W-1:0]);
        REG_REV_MIN:     regs.rev_min     <= $signed(data[COEF_W-1:0]);
        REG_REV_MAX:     regs.rev_max     <= $signed(data[COEF_W-1:0]);
        REG_OPEN_ANGLE:  regs.open_angle  <= data[ANGLE_W-1:0];
        REG_CLOSE_ANGLE: regs.close_angle <= data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/srpi_muldiv.sv
// ----------------------------------------------------------------------------
// srpi_muldiv: bit-serial signed a*b/d, truncated toward zero
// Shift-add multiply one multiplier bit per cycle, then restoring division
// one quotient bit per cycle on magnitudes; the sign is applied at the end.
// ----------------------------------------------------------------------------
module srpi_muldiv #(
  parameter int SAMPLE_BITS = srpi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [SAMPLE_BITS+8:0]    a,
  input  logic signed [srpi_pkg::COEF_W:0] b,
  input  logic signed [SAMPLE_BITS:0]      d,
  output logic signed [SAMPLE_BITS+16:0]   q,
  output srpi_pkg::md_stat_t               stat
);
  import srpi_pkg::*;

  localparam int AW = SAMPLE_BITS + 8;   // magnitude bits of a
  localparam int DW = SAMPLE_BITS;       // magnitude bits of d
  localparam int PW = AW + COEF_W;       // product / quotient bits
  localparam int CW = $clog2(PW);

  md_state_t         state, state_next;
  logic [CW-1:0]     cnt;
  logic [PW-1:0]     acc;       // product, then dividend/quotient shift register
  logic [PW-1:0]     mcand;
  logic [COEF_W-1:0] mplier;
  logic [DW-1:0]     divisor;
  logic [DW-1:0]     rem;
  logic              neg;
  logic              done;

  logic [AW:0]       a_abs;
  logic [COEF_W:0]   b_abs;
  logic [DW:0]       d_abs;
  logic [DW:0]       shifted;
  logic [DW+1:0]     diff;

  assign a_abs   = a[AW] ? $unsigned(-a) : $unsigned(a);
  assign b_abs   = b[COEF_W] ? $unsigned(-b) : $unsigned(b);
  assign d_abs   = d[DW] ? $unsigned(-d) : $unsigned(d);
  assign shifted = {rem, acc[PW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MD_DIV) && (cnt == '0);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (start) state_next = MD_MUL;
      MD_MUL:  if (cnt == '0) state_next = MD_DIV;
      MD_DIV:  if (cnt == '0) state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          acc     <= '0;
          mcand   <= PW'(a_abs[AW-1:0]);
          mplier  <= b_abs[COEF_W-1:0];
          divisor <= d_abs[DW-1:0];
          rem     <= '0;
          neg     <= a[AW] ^ b[COEF_W] ^ d[DW];
          cnt     <= CW'(COEF_W - 1);
        end
      end
      MD_MUL: begin
        acc    <= acc + (mplier[0] ? mcand : '0);
        mcand  <= {mcand[PW-2:0], 1'b0};
        mplier <= {1'b0, mplier[COEF_W-1:1]};
        cnt    <= (cnt == '0) ? CW'(PW - 1) : cnt - 1'b1;
      end
      MD_DIV: begin
        if (!diff[DW+1]) begin
          rem <= diff[DW-1:0];
          acc <= {acc[PW-2:0], 1'b1};
        end else begin
          rem <= shifted[DW-1:0];
          acc <= {acc[PW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign q         = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  assign stat.busy = (state != MD_IDLE);
  assign stat.done = done;

endmodule

### hw/rtl/sensor_rate_position_integrator.sv
// ----------------------------------------------------------------------------
// sensor_rate_position_integrator: sensor sample to speed, position and angle
// Calibrates, normalizes, picks a speed, integrates a clamped position and
// maps it to a servo angle, using one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transaction per sensor sample; tdata carries the
//    sample, tuser the mode (run, restart calibration, calibration update).
//  - Output stream (m_*): exactly one result transaction per input
//    transaction, in order: speed, position, servo angle, calib min and max.
//  - Config port: cfg_we/cfg_index/cfg_data write one register per cycle;
//    write only while no transaction is in flight.
//  - Throughput: one item at a time. Each run or update item uses the serial
//    unit up to three times (normalize, speed, angle); each pass shifts through
//    8 multiply bits, then SAMPLE_BITS+16 quotient bits. The next item can be
//    taken in the cycle after the result loads. Passes are skipped when the
//    span is zero or the speed is taken straight from a register. Restart
//    items skip the serial unit and go straight to the output state.
//  - s_tready is high whenever the sequencer is idle, even while a finished
//    result still sits in the output register; a stalled receiver holds the
//    output register and only the finish of the following item waits.
//  - Reset (rst, synchronous) restores the register defaults, clears the
//    calibration to 0..0, the position to its low end and drops m_tvalid.
// ----------------------------------------------------------------------------
module sensor_rate_position_integrator #(
  parameter int SAMPLE_BITS = srpi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  // [1:0] mode
  input  logic [1:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // speed[8:0], position[15:9], servo_angle[23:16], calib_low, calib_high
  // (SAMPLE_BITS each, from bit 24 up), rest zero
  output logic [((2*SAMPLE_BITS+24+7)/8)*8-1:0]   m_tdata,
  input  logic                                    cfg_we,
  input  logic [srpi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [srpi_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import srpi_pkg::*;

  localparam int NW    = SAMPLE_BITS + 8;             // signed normalized value
  localparam int PW    = NW + COEF_W;                 // serial unit quotient bits
  localparam int OUT_W = ((2*SAMPLE_BITS + 24 + 7) / 8) * 8;

  localparam logic signed [PW+1:0] SAT_POS = (PW+2)'(SPEED_SAT);
  localparam logic signed [PW+1:0] SAT_NEG = (PW+2)'(-SPEED_SAT);

  cfg_t                     cfg;
  seq_state_t               state, state_next;

  logic [SAMPLE_BITS-1:0]   sample_in;
  logic                     accept;
  logic                     out_load;

  // item state
  logic [SAMPLE_BITS-1:0]   sample_r;
  logic [SAMPLE_BITS-1:0]   calib_min;
  logic [SAMPLE_BITS-1:0]   calib_max;
  logic [HELD_W-1:0]        held;
  logic signed [NW-1:0]     norm;
  logic signed [COEF_W-1:0] base;
  logic signed [SPEED_W-1:0] speed_r;
  logic [ANGLE_W-1:0]       angle_r;

  // serial unit hookup
  logic                      md_start;
  logic signed [NW:0]        md_a;
  logic signed [COEF_W:0]    md_b;
  logic signed [SAMPLE_BITS:0] md_d;
  logic signed [PW:0]        md_q;
  md_stat_t                  md_stat;

  // operands
  logic [SAMPLE_BITS-1:0]      span;
  logic signed [SAMPLE_BITS:0] diff_norm;
  logic signed [NW:0]          a_fwd;
  logic signed [COEF_W:0]      b_fwd;
  logic signed [SAMPLE_BITS:0] d_fwd;
  logic signed [COEF_W:0]      b_rev;
  logic signed [COEF_W:0]      b_ang;
  logic                        fwd_hit;
  logic                        band_hit;
  logic signed [COEF_W-1:0]    base_sel;
  logic signed [PW+1:0]        speed_sum;
  logic signed [HELD_W+2:0]    pos_sum;
  logic [HELD_W-1:0]           pos_clamp;

  srpi_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .regs  (cfg)
  );

  srpi_muldiv #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .q     (md_q),
    .stat  (md_stat)
  );

  assign sample_in = s_tdata[SAMPLE_BITS-1:0];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // calibration span never goes negative: updates only lower min or raise max, restart sets both
  assign span      = calib_max - calib_min;
  assign diff_norm = $signed({1'b0, sample_r}) - $signed({1'b0, calib_min});

  // speed selection; tests run forward, band, reverse even with an inverted band
  assign fwd_hit  = norm > $signed(NW'(cfg.stop_high));
  assign band_hit = norm > $signed(NW'(cfg.stop_low));
  assign base_sel = (fwd_hit || band_hit) ? cfg.fwd_min : cfg.rev_min;

  assign a_fwd = (NW+1)'(norm) - $signed((NW+1)'(cfg.stop_high));
  assign b_fwd = (COEF_W+1)'(cfg.fwd_max) - (COEF_W+1)'(cfg.fwd_min);
  assign d_fwd = $signed((SAMPLE_BITS+1)'(NORM_HIGH))
               - $signed((SAMPLE_BITS+1)'(cfg.stop_high));
  assign b_rev = (COEF_W+1)'(cfg.rev_max) - (COEF_W+1)'(cfg.rev_min);
  assign b_ang = $signed((COEF_W+1)'(cfg.close_angle))
               - $signed((COEF_W+1)'(cfg.open_angle));

  assign speed_sum = $signed({md_q[PW], md_q}) + (PW+2)'(base);

  // position integration with clamp
  assign pos_sum = $signed((HELD_W+3)'(held)) + (HELD_W+3)'(speed_r);

  always_comb begin
    if (pos_sum > $signed((HELD_W+3)'(POSITION_HIGH))) begin
      pos_clamp = HELD_W'(POSITION_HIGH);
    end else if (pos_sum < $signed((HELD_W+3)'(POSITION_LOW))) begin
      pos_clamp = HELD_W'(POSITION_LOW);
    end else begin
      pos_clamp = pos_sum[HELD_W-1:0];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    md_start   = 1'b0;
    md_a       = (NW+1)'(diff_norm);
    md_b       = (COEF_W+1)'(NORM_HIGH);
    md_d       = $signed({1'b0, span});
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (mode_t'(s_tuser) == MODE_RESTART) ? ST_OUT : ST_NORM;
        end
      end
      ST_NORM: begin
        if (span == '0) begin
          state_next = ST_SPEED;
        end else begin
          md_start   = 1'b1;
          state_next = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        if (md_stat.done) state_next = ST_SPEED;
      end
      ST_SPEED: begin
        if (fwd_hit) begin
          if (cfg.stop_high == STOP_W'(NORM_HIGH)) begin
            state_next = ST_POS;   // empty forward range: lower endpoint
          end else begin
            md_start   = 1'b1;
            md_a       = a_fwd;
            md_b       = b_fwd;
            md_d       = d_fwd;
            state_next = ST_SPEED_WAIT;
          end
        end else if (band_hit || cfg.stop_low == '0) begin
          state_next = ST_POS;
        end else begin
          md_start   = 1'b1;
          md_a       = (NW+1)'(norm);
          md_b       = b_rev;
          md_d       = $signed((SAMPLE_BITS+1)'(cfg.stop_low));
          state_next = ST_SPEED_WAIT;
        end
      end
      ST_SPEED_WAIT: begin
        if (md_stat.done) state_next = ST_POS;
      end
      ST_POS: begin
        md_start   = 1'b1;
        md_a       = $signed((NW+1)'(pos_clamp));
        md_b       = b_ang;
        md_d       = $signed((SAMPLE_BITS+1)'(POSITION_HIGH));
        state_next = ST_ANGLE_WAIT;
      end
      ST_ANGLE_WAIT: begin
        if (md_stat.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // calibration, held position, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_min <= '0;
      calib_max <= '0;
      held      <= HELD_W'(POSITION_LOW);
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        case (mode_t'(s_tuser))
          MODE_RESTART: begin
            calib_min <= sample_in;
            calib_max <= sample_in;
          end
          MODE_UPDATE: begin
            if (sample_in < calib_min) begin
              calib_min <= sample_in;
            end else if (sample_in > calib_max) begin
              calib_max <= sample_in;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_POS) held <= pos_clamp;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample_in;
      speed_r  <= '0;                 // restart: no motion
      angle_r  <= cfg.open_angle;
    end
    case (state)
      ST_NORM:      if (span == '0) norm <= NW'(NORM_LOW);
      ST_NORM_WAIT: if (md_stat.done) norm <= md_q[NW-1:0];
      ST_SPEED: begin
        base    <= base_sel;
        speed_r <= SPEED_W'(base_sel);
      end
      ST_SPEED_WAIT: begin
        if (md_stat.done) begin
          if (speed_sum > SAT_POS) begin
            speed_r <= SPEED_W'(SPEED_SAT);
          end else if (speed_sum < SAT_NEG) begin
            speed_r <= SPEED_W'(-SPEED_SAT);
          end else begin
            speed_r <= speed_sum[SPEED_W-1:0];
          end
        end
      end
      ST_ANGLE_WAIT: begin
        if (md_stat.done) angle_r <= md_q[ANGLE_W-1:0] + cfg.open_angle;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= OUT_W'({calib_max, calib_min, angle_r, held[POS_OUT_W-1:0], speed_r});
    end
  end

  // checks
  a_calib_order: assert property (@(posedge clk) disable iff (rst)
    calib_min <= calib_max)
    else $error("calibration min above max");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(POSITION_HIGH))
    else $error("held position above upper limit");

  a_md_start_idle: assert property (@(posedge clk) disable iff (rst)
    md_start |-> !md_stat.busy)
    else $error("serial unit started while busy");

  a_wait_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM_WAIT || state == ST_SPEED_WAIT || state == ST_ANGLE_WAIT)
      && !md_stat.busy |-> md_stat.done)
    else $error("waiting on serial unit that is neither busy nor done");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result transaction raised outside output state");

endmodule
